// ----- sv/txr_pkg.sv -----
package txr_pkg;

	localparam int MAX_COLUMNS_DEF  = 128;
	localparam int MAX_ROWS_DEF     = 64;
	localparam int GLYPH_HEIGHT_DEF = 16;
	localparam int GLYPH_COUNT_DEF  = 256;

	localparam int CELL_PIXELS = 9;

	localparam logic [7:0] COLS_RST = 8'd80;
	localparam logic [6:0] ROWS_RST = 7'd25;

	localparam logic [1:0] FN_FONT       = 2'd0;
	localparam logic [1:0] FN_CURSOR_POS = 2'd1;
	localparam logic [1:0] FN_CURSOR_EN  = 2'd2;
	localparam logic [1:0] FN_WRITE_CELL = 2'd3;

	localparam logic REG_GRID_COLUMNS = 1'b0;
	localparam logic REG_GRID_ROWS    = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_GLYPH,
		S_RENDER
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [6:0]  col;
		logic [5:0]  row;
		logic [15:0] entry;
		logic        cursor_on;
	} req_t;

	typedef struct packed {
		logic [8:0] cols;
		logic [7:0] rows;
	} grid_t;

	function automatic logic [31:0] palette_color(input logic [3:0] idx);
		logic [7:0] level;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		level = idx[3] ? 8'hFF : 8'hBF;
		r = idx[2] ? level : 8'h00;
		g = idx[1] ? level : 8'h00;
		b = idx[0] ? level : 8'h00;
		return {8'hFF, r, g, b};
	endfunction

	function automatic logic cell_in_range(input logic [6:0] col, input logic [5:0] row,
			input grid_t grid);
		return ({2'b00, col} < grid.cols) && ({2'b00, row} < grid.rows);
	endfunction

endpackage

// ----- sv/txr_ram.sv -----
module txr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ----- sv/txr_seq.sv -----
module txr_seq #(
	parameter int MAX_COLUMNS  = txr_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS     = txr_pkg::MAX_ROWS_DEF,
	parameter int GLYPH_HEIGHT = txr_pkg::GLYPH_HEIGHT_DEF,
	parameter int CA_W         = 13,
	parameter int FA_W         = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  txr_pkg::req_t       req,
	input  txr_pkg::grid_t      grid,
	output logic                busy,
	output logic                char_we,
	output logic [CA_W-1:0]     char_waddr,
	output logic [15:0]         char_wdata,
	output logic [CA_W-1:0]     char_raddr,
	input  logic [15:0]         char_rdata,
	output logic [FA_W-1:0]     font_raddr,
	input  logic [7:0]          font_rdata,
	output logic                result_strobe,
	output logic [9:0]          pixel_row,
	output logic [10:0]         pixel_col,
	output logic [8:0]          fg_mask,
	output logic [31:0]         fg_color,
	output logic [31:0]         bg_color,
	output logic                last_row
);

	import txr_pkg::*;

	localparam int CHAR_DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int Y_W        = $clog2(GLYPH_HEIGHT);
	localparam int PW         = CA_W + 8;

	state_t state_q, state_d;

	logic [CA_W-1:0] clr_q;
	logic [6:0]      cur_col_q;
	logic [5:0]      cur_row_q;
	logic            cur_en_q;

	logic [6:0]      t0_col_q, t1_col_q;
	logic [5:0]      t0_row_q, t1_row_q;
	logic            two_q, sel_q;

	logic [7:0]      glyph_q;
	logic [31:0]     fg_q, bg_q;
	logic            csr_q;
	logic [Y_W-1:0]  y_q;

	logic            valid_s1, cline_s1, last_s1;
	logic [9:0]      prow_s1;
	logic [10:0]     pcol_s1;
	logic [31:0]     fg_s1, bg_s1;

	logic            strobe_q, last_q;
	logic [9:0]      prow_q;
	logic [10:0]     pcol_q;
	logic [8:0]      mask_q;
	logic [31:0]     fgc_q, bgc_q;

	logic            accept, req_ok, old_ok, a_v, b_v, y_last;
	logic [6:0]      a_col, cell_col;
	logic [5:0]      a_row, cell_row;
	logic [PW-1:0]   waddr_full, raddr_full;
	logic [11:0]     prow_full;
	logic [10:0]     pcol_full;
	logic [7:0]      font_rev;

	assign cell_col   = sel_q ? t1_col_q : t0_col_q;
	assign cell_row   = sel_q ? t1_row_q : t0_row_q;
	assign waddr_full = PW'(req.row) * PW'(MAX_COLUMNS) + PW'(req.col);
	assign raddr_full = PW'(cell_row) * PW'(MAX_COLUMNS) + PW'(cell_col);
	assign char_raddr = raddr_full[CA_W-1:0];
	assign font_raddr = FA_W'(glyph_q) * FA_W'(GLYPH_HEIGHT) + FA_W'(y_q);
	assign prow_full  = 12'(cell_row) * 12'(GLYPH_HEIGHT) + 12'(y_q);
	assign pcol_full  = 11'(cell_col) * 11'(CELL_PIXELS);
	assign y_last     = (y_q == Y_W'(GLYPH_HEIGHT - 1));
	assign accept     = start && !busy;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			font_rev[k] = font_rdata[7-k];
		end
	end

	// cells touched by the request
	always_comb begin
		req_ok = cell_in_range(req.col, req.row, grid);
		old_ok = cell_in_range(cur_col_q, cur_row_q, grid);
		a_col  = req.col;
		a_row  = req.row;
		a_v    = 1'b0;
		b_v    = 1'b0;
		unique case (req.func)
			FN_FONT: begin
				a_v = 1'b0;
			end
			FN_CURSOR_POS: begin
				a_col = cur_col_q;
				a_row = cur_row_q;
				a_v   = old_ok;
				b_v   = req_ok;
			end
			FN_CURSOR_EN: begin
				a_col = cur_col_q;
				a_row = cur_row_q;
				a_v   = (req.cursor_on != cur_en_q) && old_ok;
			end
			FN_WRITE_CELL: begin
				a_v = req_ok;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CA_W'(CHAR_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept && (a_v || b_v)) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_GLYPH;
			end
			S_GLYPH: begin
				state_d = S_RENDER;
			end
			S_RENDER: begin
				if (y_last) begin
					state_d = (!sel_q && two_q) ? S_FETCH : S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		busy       = (state_q != S_IDLE) || valid_s1;
		char_we    = 1'b0;
		char_waddr = waddr_full[CA_W-1:0];
		char_wdata = req.entry;
		unique case (state_q)
			S_CLEAR: begin
				char_we    = 1'b1;
				char_waddr = clr_q;
				char_wdata = '0;
			end
			S_IDLE: begin
				char_we = start && !valid_s1 && (req.func == FN_WRITE_CELL) && req_ok;
			end
			S_FETCH, S_GLYPH, S_RENDER: begin
				char_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			cur_en_q  <= 1'b1;
			t0_col_q  <= '0;
			t0_row_q  <= '0;
			t1_col_q  <= '0;
			t1_row_q  <= '0;
			two_q     <= 1'b0;
			sel_q     <= 1'b0;
			y_q       <= '0;
			valid_s1  <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == S_RENDER);
			strobe_q <= valid_s1;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				if (req.func == FN_CURSOR_POS) begin
					cur_col_q <= req.col;
					cur_row_q <= req.row;
				end
				if (req.func == FN_CURSOR_EN) begin
					cur_en_q <= req.cursor_on;
				end
				t0_col_q <= a_v ? a_col : req.col;
				t0_row_q <= a_v ? a_row : req.row;
				t1_col_q <= req.col;
				t1_row_q <= req.row;
				two_q    <= a_v && b_v;
				sel_q    <= 1'b0;
			end
			if (state_q == S_GLYPH) begin
				y_q <= '0;
			end else if (state_q == S_RENDER) begin
				y_q <= y_q + 1'b1;
				if (y_last) begin
					sel_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GLYPH) begin
			glyph_q <= char_rdata[7:0];
			fg_q    <= palette_color(char_rdata[11:8]);
			bg_q    <= palette_color(char_rdata[15:12]);
			csr_q   <= cur_en_q && (cell_col == cur_col_q) && (cell_row == cur_row_q);
		end
		if (state_q == S_RENDER) begin
			prow_s1  <= prow_full[9:0];
			pcol_s1  <= pcol_full;
			cline_s1 <= csr_q && (y_q >= Y_W'(GLYPH_HEIGHT - 2));
			last_s1  <= y_last && !(!sel_q && two_q);
			fg_s1    <= fg_q;
			bg_s1    <= bg_q;
		end
		if (valid_s1) begin
			prow_q <= prow_s1;
			pcol_q <= pcol_s1;
			mask_q <= cline_s1 ? 9'h1FF : {1'b0, font_rev};
			fgc_q  <= fg_s1;
			bgc_q  <= bg_s1;
			last_q <= last_s1;
		end
	end

	assign result_strobe = strobe_q;
	assign pixel_row     = prow_q;
	assign pixel_col     = pcol_q;
	assign fg_mask       = mask_q;
	assign fg_color      = fgc_q;
	assign bg_color      = bgc_q;
	assign last_row      = last_q;

endmodule

// ----- sv/text_cell_glyph_renderer_top.sv -----
// Text cell glyph renderer: character grid plus loaded font, rendered to glyph pixel rows.
// Requests: a request is taken at a rising edge with start high and busy low. func selects
// a font byte load, a cursor move, a cursor enable change or a cell write.
// Results: one result per glyph line, shown for exactly one cycle with result_strobe high;
// last_row marks the final result of a request. The receiver cannot hold results off.
// Configuration: cfg_we with cfg_idx 0 (grid columns) or 1 (grid rows), only while idle.
// Timing: a font load, or a request that renders nothing, leaves busy low. Each rendered
// cell runs a char store read, a glyph setup step, then one font store read and one result
// per cycle for each glyph line; two output stages follow the last. A cursor move renders
// the old and then the new cursor cell when both lie in the grid. busy drops in the cycle
// its last result is shown, so the next request is taken only after that result. Rate is
// set by the single font read port.
// Reset: the char store is swept to zero, one entry per cycle, over its MAX_ROWS * MAX_COLUMNS
// entries (8192 by default) with busy high; configuration writes are taken meanwhile.
// Cursor resets to cell 0,0 enabled; grid resets to 80 columns by 25 rows.
module text_cell_glyph_renderer_top #(
	parameter int MAX_COLUMNS  = txr_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS     = txr_pkg::MAX_ROWS_DEF,
	parameter int GLYPH_HEIGHT = txr_pkg::GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT  = txr_pkg::GLYPH_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [6:0]  cell_col,
	input  logic [5:0]  cell_row,
	input  logic [15:0] cell_entry,
	input  logic [11:0] font_addr,
	input  logic [7:0]  font_byte,
	input  logic        cursor_on,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [7:0]  cfg_data,
	output logic        result_strobe,
	output logic [9:0]  pixel_row,
	output logic [10:0] pixel_col,
	output logic [8:0]  fg_mask,
	output logic [31:0] fg_color,
	output logic [31:0] bg_color,
	output logic        last_row
);

	import txr_pkg::*;

	localparam int CHAR_DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int CA_W       = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;
	localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int FA_W       = $clog2(FONT_DEPTH);

	logic [7:0]      cols_q;
	logic [6:0]      rows_q;
	grid_t           grid;
	req_t            req;

	logic            char_we;
	logic [CA_W-1:0] char_waddr, char_raddr;
	logic [15:0]     char_wdata, char_rdata;
	logic            font_we;
	logic [FA_W-1:0] font_raddr;
	logic [7:0]      font_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_COLUMNS: cols_q <= cfg_data;
				REG_GRID_ROWS:    rows_q <= cfg_data[6:0];
			endcase
		end
	end

	// grid size saturated to the store
	assign grid.cols = ({1'b0, cols_q} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : {1'b0, cols_q};
	assign grid.rows = ({1'b0, rows_q} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : {1'b0, rows_q};

	assign req.func      = func;
	assign req.col       = cell_col;
	assign req.row       = cell_row;
	assign req.entry     = cell_entry;
	assign req.cursor_on = cursor_on;

	assign font_we = start && !busy && (func == FN_FONT)
		&& ({2'b00, font_addr} < 14'(FONT_DEPTH));

	txr_ram #(
		.WIDTH (16),
		.DEPTH (CHAR_DEPTH),
		.AW    (CA_W)
	) u_char_ram (
		.clk     (clk),
		.we      (char_we),
		.waddr   (char_waddr),
		.wdata   (char_wdata),
		.raddr   (char_raddr),
		.rdata_q (char_rdata)
	);

	txr_ram #(
		.WIDTH (8),
		.DEPTH (FONT_DEPTH),
		.AW    (FA_W)
	) u_font_ram (
		.clk     (clk),
		.we      (font_we),
		.waddr   (FA_W'(font_addr)),
		.wdata   (font_byte),
		.raddr   (font_raddr),
		.rdata_q (font_rdata)
	);

	txr_seq #(
		.MAX_COLUMNS  (MAX_COLUMNS),
		.MAX_ROWS     (MAX_ROWS),
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.CA_W         (CA_W),
		.FA_W         (FA_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req           (req),
		.grid          (grid),
		.busy          (busy),
		.char_we       (char_we),
		.char_waddr    (char_waddr),
		.char_wdata    (char_wdata),
		.char_raddr    (char_raddr),
		.char_rdata    (char_rdata),
		.font_raddr    (font_raddr),
		.font_rdata    (font_rdata),
		.result_strobe (result_strobe),
		.pixel_row     (pixel_row),
		.pixel_col     (pixel_col),
		.fg_mask       (fg_mask),
		.fg_color      (fg_color),
		.bg_color      (bg_color),
		.last_row      (last_row)
	);

endmodule

// ----- sv/txr_check.sv -----
module txr_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       result_strobe,
	input logic       last_row
);

	import txr_pkg::*;

	// font loads produce nothing
	a_font_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (func == FN_FONT) |=> !result_strobe)
		else $error("result after font load");

	// more results pending keeps the block busy
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_row |-> busy)
		else $error("idle with results pending");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !result_strobe)
		else $error("result while idle");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_row |=> !result_strobe)
		else $error("result right after last row");

endmodule

bind text_cell_glyph_renderer_top txr_check u_txr_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.func          (func),
	.result_strobe (result_strobe),
	.last_row      (last_row)
);
